### hw/rtl/bls_pkg.sv
// ----------------------------------------------------------------------------
// bls_pkg: shared types for the Bresenham line stepper
// Opcode codes carried on the input tuser field.
// ----------------------------------------------------------------------------
`default_nettype none

package bls_pkg;

  // Input item kind.
  typedef enum logic [0:0] {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_t;

endpackage : bls_pkg

`default_nettype wire

### hw/rtl/bls_setup.sv
// ----------------------------------------------------------------------------
// bls_setup: line setup for a load item
// Picks the major axis, the step directions, the start position, the error
// term and its two increments, and the pixel count from two endpoints.
// ----------------------------------------------------------------------------
`default_nettype none

module bls_setup #(
  parameter int COORD_BITS = 12,
  localparam int ERR_W = COORD_BITS + 3
) (
  input  logic [COORD_BITS-1:0]   x_start,
  input  logic [COORD_BITS-1:0]   y_start,
  input  logic [COORD_BITS-1:0]   x_end,
  input  logic [COORD_BITS-1:0]   y_end,
  output logic                    axes_swapped,
  output logic                    major_step_negative,
  output logic                    minor_step_negative,
  output logic [COORD_BITS-1:0]   major_start,
  output logic [COORD_BITS-1:0]   minor_start,
  output logic signed [ERR_W-1:0] error_start,
  output logic signed [ERR_W-1:0] up_increment,
  output logic signed [ERR_W-1:0] down_increment,
  output logic [COORD_BITS:0]     pixel_count
);

  logic [COORD_BITS-1:0] dx;
  logic [COORD_BITS-1:0] dy;
  logic [COORD_BITS-1:0] dmaj;
  logic [COORD_BITS-1:0] dmin;
  logic [COORD_BITS-1:0] major_end;
  logic [COORD_BITS-1:0] minor_end;
  logic signed [ERR_W-1:0] two_dmin;
  logic signed [ERR_W-1:0] two_dmaj;
  logic signed [ERR_W-1:0] one_dmaj;

  // Absolute spans on both axes.
  assign dx = (x_start >= x_end) ? (x_start - x_end) : (x_end - x_start);
  assign dy = (y_start >= y_end) ? (y_start - y_end) : (y_end - y_start);

  // A steep line runs along y.
  assign axes_swapped = (dx < dy);

  always_comb begin
    if (axes_swapped) begin
      major_start = y_start;
      major_end   = y_end;
      minor_start = x_start;
      minor_end   = x_end;
      dmaj        = dy;
      dmin        = dx;
    end else begin
      major_start = x_start;
      major_end   = x_end;
      minor_start = y_start;
      minor_end   = y_end;
      dmaj        = dx;
      dmin        = dy;
    end
  end

  assign major_step_negative = (major_start > major_end);
  assign minor_step_negative = (minor_start > minor_end);

  // Error term and increments, all non-negative spans widened before use.
  assign two_dmin = $signed({2'b00, dmin, 1'b0});
  assign two_dmaj = $signed({2'b00, dmaj, 1'b0});
  assign one_dmaj = $signed({3'b000, dmaj});

  assign error_start    = two_dmin - one_dmaj;
  assign up_increment   = two_dmin - two_dmaj;
  assign down_increment = two_dmin;

  // A line covers the major span plus one pixel.
  assign pixel_count = {1'b0, dmaj} + {{COORD_BITS{1'b0}}, 1'b1};

endmodule : bls_setup

`default_nettype wire

### hw/rtl/bls_core.sv
// ----------------------------------------------------------------------------
// bls_core: line state and per-pixel step
// Holds the line state, loads it from the setup logic and advances it one
// pixel per step item while any remain; one result for every accepted item.
// ----------------------------------------------------------------------------
`default_nettype none

module bls_core #(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  bls_pkg::op_t          opcode,
  input  logic [COORD_BITS-1:0] x_start,
  input  logic [COORD_BITS-1:0] y_start,
  input  logic [COORD_BITS-1:0] x_end,
  input  logic [COORD_BITS-1:0] y_end,
  output logic                  res_pixel_valid,
  output logic [COORD_BITS-1:0] res_pixel_x,
  output logic [COORD_BITS-1:0] res_pixel_y,
  output logic                  res_last_pixel
);

  import bls_pkg::*;

  localparam int ERR_W = COORD_BITS + 3;

  // Line state.
  logic [COORD_BITS-1:0]   major_pos;
  logic [COORD_BITS-1:0]   minor_pos;
  logic signed [ERR_W-1:0] error_term;
  logic signed [ERR_W-1:0] up_increment;
  logic signed [ERR_W-1:0] down_increment;
  logic [COORD_BITS:0]     pixels_left;
  logic                    major_step_negative;
  logic                    minor_step_negative;
  logic                    axes_swapped;

  // Setup values for a load.
  logic                    su_swapped;
  logic                    su_major_neg;
  logic                    su_minor_neg;
  logic [COORD_BITS-1:0]   su_major_start;
  logic [COORD_BITS-1:0]   su_minor_start;
  logic signed [ERR_W-1:0] su_error;
  logic signed [ERR_W-1:0] su_up;
  logic signed [ERR_W-1:0] su_down;
  logic [COORD_BITS:0]     su_count;

  logic                    drawing;
  logic                    minor_step;
  logic [COORD_BITS-1:0]   major_pos_next;
  logic [COORD_BITS-1:0]   minor_pos_next;
  logic signed [ERR_W-1:0] error_term_next;

  bls_setup #(
    .COORD_BITS (COORD_BITS)
  ) u_setup (
    .x_start             (x_start),
    .y_start             (y_start),
    .x_end               (x_end),
    .y_end               (y_end),
    .axes_swapped        (su_swapped),
    .major_step_negative (su_major_neg),
    .minor_step_negative (su_minor_neg),
    .major_start         (su_major_start),
    .minor_start         (su_minor_start),
    .error_start         (su_error),
    .up_increment        (su_up),
    .down_increment      (su_down),
    .pixel_count         (su_count)
  );

  assign drawing    = (pixels_left != '0);
  assign minor_step = (error_term > $signed({ERR_W{1'b0}}));

  // Next position and error term for one pixel step.
  always_comb begin
    major_pos_next  = major_step_negative ? (major_pos - 1'b1) : (major_pos + 1'b1);
    if (minor_step) begin
      minor_pos_next  = minor_step_negative ? (minor_pos - 1'b1) : (minor_pos + 1'b1);
      error_term_next = error_term + up_increment;
    end else begin
      minor_pos_next  = minor_pos;
      error_term_next = error_term + down_increment;
    end
  end

  // Result for the item being accepted; loads and idle steps give zeros.
  always_comb begin
    res_pixel_valid = 1'b0;
    res_pixel_x     = '0;
    res_pixel_y     = '0;
    res_last_pixel  = 1'b0;
    if (opcode == OP_STEP && drawing) begin
      res_pixel_valid = 1'b1;
      res_pixel_x     = axes_swapped ? minor_pos : major_pos;
      res_pixel_y     = axes_swapped ? major_pos : minor_pos;
      res_last_pixel  = (pixels_left == (COORD_BITS + 1)'(1));
    end
  end

  // State update.
  always_ff @(posedge clk) begin
    if (rst) begin
      major_pos           <= '0;
      minor_pos           <= '0;
      error_term          <= '0;
      up_increment        <= '0;
      down_increment      <= '0;
      pixels_left         <= '0;
      major_step_negative <= 1'b0;
      minor_step_negative <= 1'b0;
      axes_swapped        <= 1'b0;
    end else if (accept) begin
      case (opcode)
        OP_LOAD: begin
          major_pos           <= su_major_start;
          minor_pos           <= su_minor_start;
          error_term          <= su_error;
          up_increment        <= su_up;
          down_increment      <= su_down;
          pixels_left         <= su_count;
          major_step_negative <= su_major_neg;
          minor_step_negative <= su_minor_neg;
          axes_swapped        <= su_swapped;
        end
        OP_STEP: begin
          if (drawing) begin
            major_pos   <= major_pos_next;
            minor_pos   <= minor_pos_next;
            error_term  <= error_term_next;
            pixels_left <= pixels_left - 1'b1;
          end
        end
        default: begin
          pixels_left <= pixels_left;
        end
      endcase
    end
  end

endmodule : bls_core

`default_nettype wire

### hw/rtl/bls_out_skid.sv
// ----------------------------------------------------------------------------
// bls_out_skid: two-entry output buffer
// A result register plus a skid entry, so that an item can be accepted while
// the previous result still waits on the output.
// ----------------------------------------------------------------------------
`default_nettype none

module bls_out_skid #(
  parameter int WIDTH = 26
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  logic             skid_valid;
  logic [WIDTH-1:0] skid_data;
  logic             push;
  logic             pop;

  assign in_ready = !skid_valid;
  assign push     = in_valid && in_ready;
  assign pop      = out_valid && out_ready;

  // Valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (push) begin
      if (out_valid && !pop) begin
        skid_data <= in_data;
      end else begin
        out_data <= in_data;
      end
    end else if (pop && skid_valid) begin
      out_data <= skid_data;
    end
  end

  // The skid entry is only ever filled behind a held result.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry holds an item while the output is empty");

  // An item arriving on a stalled output goes to the skid entry.
  a_stall_to_skid: assert property (@(posedge clk) disable iff (rst)
    (push && out_valid && !out_ready) |=> skid_valid)
    else $error("item accepted on a stalled output was not parked");

  // A drained skid entry moves to the output in order.
  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && out_ready) |=> (out_valid && !skid_valid &&
                                    out_data == $past(skid_data)))
    else $error("skid entry did not move to the output");

endmodule : bls_out_skid

`default_nettype wire

### hw/rtl/bresenham_line_stepper.sv
// ----------------------------------------------------------------------------
// bresenham_line_stepper: Bresenham line rasterizer, all octants
// A load item sets up a line from two endpoints; each step item returns the
// next pixel of that line and flags the final one.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake                    Contents
//  s_axis   in   s_axis_tvalid/s_axis_tready  tuser opcode, tdata endpoints
//  m_axis   out  m_axis_tvalid/m_axis_tready  tuser pixel_valid, tdata x/y,
//                                             tlast last_pixel
//
//  One item is taken per cycle while ready is high; its result is registered.
//  The line state update (one add and compare) sits between the state
//  registers and a two-entry output buffer, which sets the one-per-cycle rate.
//  Input ready drops only when both output entries are full.
//  Reset clears the line state (idle) and empties the output buffer.
//
`default_nettype none

module bresenham_line_stepper #(
  parameter int COORD_BITS = 12,
  localparam int IN_DATA_W  = ((4 * COORD_BITS + 7) / 8) * 8,
  localparam int OUT_DATA_W = ((2 * COORD_BITS + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // From bit 0: x_start, y_start, x_end, y_end, zero fill.
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // opcode.
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // From bit 0: pixel_x, pixel_y, zero fill.
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // pixel_valid.
  output logic                  m_axis_tuser,
  output logic                  m_axis_tlast
);

  import bls_pkg::*;

  localparam int RES_W = 2 * COORD_BITS + 2;

  logic                  accept;
  op_t                   opcode;
  logic                  res_pixel_valid;
  logic [COORD_BITS-1:0] res_pixel_x;
  logic [COORD_BITS-1:0] res_pixel_y;
  logic                  res_last_pixel;
  logic [RES_W-1:0]      res_packed;
  logic [RES_W-1:0]      out_packed;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign opcode = op_t'(s_axis_tuser);

  // Line state and stepping.
  bls_core #(
    .COORD_BITS (COORD_BITS)
  ) u_core (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .opcode          (opcode),
    .x_start         (s_axis_tdata[0 +: COORD_BITS]),
    .y_start         (s_axis_tdata[COORD_BITS +: COORD_BITS]),
    .x_end           (s_axis_tdata[2 * COORD_BITS +: COORD_BITS]),
    .y_end           (s_axis_tdata[3 * COORD_BITS +: COORD_BITS]),
    .res_pixel_valid (res_pixel_valid),
    .res_pixel_x     (res_pixel_x),
    .res_pixel_y     (res_pixel_y),
    .res_last_pixel  (res_last_pixel)
  );

  assign res_packed = {res_last_pixel, res_pixel_valid, res_pixel_y, res_pixel_x};

  // Result register with skid entry.
  bls_out_skid #(
    .WIDTH (RES_W)
  ) u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (res_packed),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_packed)
  );

  // Output packing.
  assign m_axis_tdata = OUT_DATA_W'(out_packed[2 * COORD_BITS - 1:0]);
  assign m_axis_tuser = out_packed[2 * COORD_BITS];
  assign m_axis_tlast = out_packed[2 * COORD_BITS + 1];

endmodule : bresenham_line_stepper

`default_nettype wire

### tb/tb_bresenham_line_stepper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bresenham_line_stepper: self-checking bench for the line stepper
// Streams load and step items into the block with random gaps and output
// stalls, predicts every pixel result with an independent rasterizer, and
// compares each output item field by field against the oldest prediction.
// ----------------------------------------------------------------------------

module tb_bresenham_line_stepper;
  import bls_pkg::*;

  localparam int          COORD_BITS  = 12;
  localparam int          IN_DATA_W   = ((4 * COORD_BITS + 7) / 8) * 8;
  localparam int          OUT_DATA_W  = ((2 * COORD_BITS + 7) / 8) * 8;
  localparam int          COORD_MAX   = (1 << COORD_BITS) - 1;
  localparam int          ITEM_TARGET = 1550;
  localparam int          CALM_TAIL   = 150;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    op_t                   opcode;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;
  } line_cmd_t;

  typedef struct packed {
    logic                  pixel_valid;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  last_pixel;
  } pixel_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  m_axis_tlast;

  line_cmd_t   pending_cmds[$];
  pixel_t      expected_pixels[$];
  line_cmd_t   current_cmd;
  int          cmds_total    = 0;
  int          cmds_accepted = 0;
  int          results_seen  = 0;
  int          send_gap      = 0;
  int          stall_left    = 0;
  int          hold_left     = 0;
  bit          hold_done     = 1'b0;
  int          error_count   = 0;
  int unsigned cycle_count   = 0;

  // Line state of the predictor.
  logic [COORD_BITS-1:0] trace_major;
  logic [COORD_BITS-1:0] trace_minor;
  int                    trace_err   = 0;
  int                    trace_up    = 0;
  int                    trace_down  = 0;
  int                    trace_left  = 0;
  bit                    major_neg   = 1'b0;
  bit                    minor_neg   = 1'b0;
  bit                    trace_steep = 1'b0;

  bresenham_line_stepper #(
    .COORD_BITS(COORD_BITS)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  function automatic int coord_span(input logic [COORD_BITS-1:0] a,
                                    input logic [COORD_BITS-1:0] b);
    return (a >= b) ? int'(a) - int'(b) : int'(b) - int'(a);
  endfunction

  // Advances the predicted line by one item and returns the pixel it yields.
  function automatic pixel_t trace_pixel(input line_cmd_t cmd);
    pixel_t                px;
    int                    dx;
    int                    dy;
    int                    dmaj;
    int                    dmin;
    logic [COORD_BITS-1:0] ms;
    logic [COORD_BITS-1:0] me;
    logic [COORD_BITS-1:0] ns;
    logic [COORD_BITS-1:0] ne;
    px = '0;
    if (cmd.opcode == OP_LOAD) begin
      dx = coord_span(cmd.x_start, cmd.x_end);
      dy = coord_span(cmd.y_start, cmd.y_end);
      trace_steep = (dx < dy);
      // A steep line runs along y, so y becomes the major axis.
      if (trace_steep) begin
        ms = cmd.y_start; me = cmd.y_end; ns = cmd.x_start; ne = cmd.x_end;
        dmaj = dy; dmin = dx;
      end else begin
        ms = cmd.x_start; me = cmd.x_end; ns = cmd.y_start; ne = cmd.y_end;
        dmaj = dx; dmin = dy;
      end
      trace_up    = 2 * dmin - 2 * dmaj;
      trace_down  = 2 * dmin;
      trace_err   = 2 * dmin - dmaj;
      major_neg   = (ms > me);
      minor_neg   = (ns > ne);
      trace_major = ms;
      trace_minor = ns;
      trace_left  = dmaj + 1;
    end else if (trace_left != 0) begin
      px.pixel_valid = 1'b1;
      px.pixel_x     = trace_steep ? trace_minor : trace_major;
      px.pixel_y     = trace_steep ? trace_major : trace_minor;
      px.last_pixel  = (trace_left == 1);
      // Positions wrap at the coordinate width once the line has ended.
      trace_major = major_neg ? trace_major - 1'b1 : trace_major + 1'b1;
      if (trace_err > 0) begin
        trace_err   += trace_up;
        trace_minor = minor_neg ? trace_minor - 1'b1 : trace_minor + 1'b1;
      end else begin
        trace_err += trace_down;
      end
      trace_left--;
    end
    return px;
  endfunction

  task automatic add_load(input int xs, input int ys, input int xe, input int ye);
    line_cmd_t cmd;
    cmd.opcode  = OP_LOAD;
    cmd.x_start = xs[COORD_BITS-1:0];
    cmd.y_start = ys[COORD_BITS-1:0];
    cmd.x_end   = xe[COORD_BITS-1:0];
    cmd.y_end   = ye[COORD_BITS-1:0];
    pending_cmds.push_back(cmd);
  endtask

  // Step items carry random coordinates, which the block must ignore.
  task automatic add_steps(input int count);
    line_cmd_t cmd;
    for (int i = 0; i < count; i++) begin
      cmd.opcode  = OP_STEP;
      cmd.x_start = COORD_BITS'($urandom_range(0, COORD_MAX));
      cmd.y_start = COORD_BITS'($urandom_range(0, COORD_MAX));
      cmd.x_end   = COORD_BITS'($urandom_range(0, COORD_MAX));
      cmd.y_end   = COORD_BITS'($urandom_range(0, COORD_MAX));
      pending_cmds.push_back(cmd);
    end
  endtask

  function automatic int offset_coord(input int c, input int d);
    if ($urandom_range(0, 1) == 1 && c >= d) return c - d;
    if (c + d <= COORD_MAX) return c + d;
    return c - d;
  endfunction

  // Loads a short line near a random point, steps it out fully, sometimes past its end.
  task automatic add_random_line();
    int xs;
    int ys;
    int xe;
    int ye;
    int reach;
    int dmaj;
    int extra;
    reach = ($urandom_range(0, 9) == 0) ? 40 : 12;
    xs    = $urandom_range(0, COORD_MAX);
    ys    = $urandom_range(0, COORD_MAX);
    xe    = offset_coord(xs, $urandom_range(0, reach));
    ye    = offset_coord(ys, $urandom_range(0, reach));
    dmaj  = coord_span(xs, xe) > coord_span(ys, ye) ? coord_span(xs, xe)
                                                    : coord_span(ys, ye);
    extra = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0;
    add_load(xs, ys, xe, ye);
    add_steps(dmaj + 1 + extra);
  endtask

  // Clock.
  initial begin
    forever #10 clk = ~clk;
  end

  // Cycle limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Driver: presents queued items and predicts each one as it is accepted.
  always @(posedge clk) begin : drive_items
    bit fired;
    bit quiet;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      fired = s_axis_tvalid && s_axis_tready;
      quiet = (cmds_total - cmds_accepted < CALM_TAIL) ||
              (cmds_accepted >= 700 && cmds_accepted < 900);
      if (fired) begin
        expected_pixels.push_back(trace_pixel(current_cmd));
        cmds_accepted++;
        if (!quiet && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(1, 19);
        end
      end
      if (!s_axis_tvalid || fired) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          current_cmd = pending_cmds.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {current_cmd.y_end, current_cmd.x_end,
                            current_cmd.y_start, current_cmd.x_start};
          s_axis_tuser  <= current_cmd.opcode;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each output item and paces the output ready.
  always @(posedge clk) begin : check_pixels
    pixel_t want;
    bit     quiet;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (expected_pixels.size() == 0) begin
          $error("pixel item with no prediction waiting: tuser %0b tdata %h tlast %0b",
                 m_axis_tuser, m_axis_tdata, m_axis_tlast);
          error_count++;
        end else begin
          want = expected_pixels.pop_front();
          if (m_axis_tuser !== want.pixel_valid) begin
            $error("pixel_valid: expected %0b, got %0b", want.pixel_valid, m_axis_tuser);
            error_count++;
          end
          if (m_axis_tdata[COORD_BITS-1:0] !== want.pixel_x) begin
            $error("pixel_x: expected %0d, got %0d",
                   want.pixel_x, m_axis_tdata[COORD_BITS-1:0]);
            error_count++;
          end
          if (m_axis_tdata[2*COORD_BITS-1:COORD_BITS] !== want.pixel_y) begin
            $error("pixel_y: expected %0d, got %0d",
                   want.pixel_y, m_axis_tdata[2*COORD_BITS-1:COORD_BITS]);
            error_count++;
          end
          if (m_axis_tlast !== want.last_pixel) begin
            $error("last_pixel: expected %0b, got %0b", want.last_pixel, m_axis_tlast);
            error_count++;
          end
        end
      end

      // One long hold-off early on lets the block fill up and stall its input.
      quiet = (cmds_total - results_seen < CALM_TAIL) ||
              (results_seen >= 500 && results_seen < 650);
      if (!hold_done && results_seen == 200) begin
        hold_done = 1'b1;
        hold_left = 150;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(0, 18);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int r;
    int xs;
    int ys;

    // Step while idle after reset.
    add_steps(1);
    // Single-point line, then a step once the line is done.
    add_load(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    add_steps(2);
    // Full-range diagonal, cut short by a new load.
    add_load(0, 0, COORD_MAX, COORD_MAX);
    add_steps(2);
    // Full-range anti-diagonal, also cut short.
    add_load(COORD_MAX, 0, 0, COORD_MAX);
    add_steps(2);
    // Full-width horizontal line, cut short.
    add_load(0, 0, COORD_MAX, 0);
    add_steps(2);
    // Steep line stepping down in both axes.
    add_load(2, COORD_MAX, 0, COORD_MAX - 4);
    add_steps(5);
    // Shallow line toward the far edge, with one step past its end.
    add_load(COORD_MAX - 2, 1, COORD_MAX, 0);
    add_steps(4);

    // Mostly complete short lines; some long lines dropped early and stray steps.
    while (pending_cmds.size() < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        add_random_line();
      end else if (r < 88) begin
        xs = $urandom_range(0, COORD_MAX);
        ys = $urandom_range(0, COORD_MAX);
        add_load(xs, ys, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
        add_steps($urandom_range(1, 8));
      end else begin
        add_steps($urandom_range(1, 3));
      end
    end
    cmds_total = pending_cmds.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (cmds_accepted < cmds_total) @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (expected_pixels.size() != 0) begin
      $error("%0d predicted pixel items never arrived", expected_pixels.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
